// ===== rtl/core/hsv_hue_transfer_core_assert.svh =====
// Assertion helpers
`ifndef HSV_HUE_TRANSFER_CORE_ASSERT_SVH
`define HSV_HUE_TRANSFER_CORE_ASSERT_SVH

`define HHT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define HHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/hht_pkg.sv =====
package hht_pkg;

  typedef struct packed {
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] hue_red;
    logic [7:0] hue_green;
    logic [7:0] hue_blue;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_t;

  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int HUE_FULL2 = 3072;
  localparam int BLEND_DEN2 = 520200;
  localparam int BLEND_SHIFT = 28;
  localparam int BLEND_RECIP = (2 ** BLEND_SHIFT + BLEND_DEN2 - 1) / BLEND_DEN2;
  localparam int STAGES = 7;

  typedef logic [RECIP_W-1:0] recip_tab_t [256];

  // ceil(2^RECIP_SHIFT / d) by shift-subtract, elaboration only
  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    logic [RECIP_W:0] num;
    logic [RECIP_W:0] q;
    logic [9:0] rem;
    tab[0] = '0;
    for (int dv = 1; dv < 256; dv++) begin
      num = (RECIP_W+1)'(2 ** RECIP_SHIFT + dv - 1);
      q = '0;
      rem = '0;
      for (int i = RECIP_W; i >= 0; i--) begin
        rem = {rem[8:0], num[i]};
        if (rem >= 10'(dv)) begin
          rem = rem - 10'(dv);
          q[i] = 1'b1;
        end
      end
      tab[dv] = q[RECIP_W-1:0];
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP = build_recip();

endpackage

// ===== rtl/core/hht_hsv.sv =====
module hht_hsv (
  input  logic          clk,
  input  logic [2:0]    en,
  input  hht_pkg::in_t  pix,
  output logic [11:0]   h2,
  output logic [8:0]    s2,
  output logic [7:0]    vmax
);

  // stage A: extremes and numerators
  logic [7:0]  mxh_c, mnh_c, dh_c, mxb_c, mnb_c, db_c;
  logic signed [21:0] ph_c;
  logic [19:0] nh_c;
  logic [17:0] ns_c;
  logic [19:0] nh_a;
  logic [7:0]  dh_a;
  logic [17:0] ns_a;
  logic [7:0]  mb_a, db_a;

  always_comb begin
    mxh_c = (pix.hue_red > pix.hue_green) ? pix.hue_red : pix.hue_green;
    mnh_c = (pix.hue_red < pix.hue_green) ? pix.hue_red : pix.hue_green;
    if (pix.hue_blue > mxh_c) mxh_c = pix.hue_blue;
    if (pix.hue_blue < mnh_c) mnh_c = pix.hue_blue;
    dh_c = mxh_c - mnh_c;
    if (mxh_c == pix.hue_red)
      ph_c = 22'(($signed({1'b0, pix.hue_green}) - $signed({1'b0, pix.hue_blue})) * 510);
    else if (mxh_c == pix.hue_green)
      ph_c = 22'(($signed({1'b0, pix.hue_blue}) - $signed({1'b0, pix.hue_red})) * 510)
           + $signed({3'b0, dh_c, 11'd0}) / 2;
    else
      ph_c = 22'(($signed({1'b0, pix.hue_red}) - $signed({1'b0, pix.hue_green})) * 510)
           + $signed({3'b0, dh_c, 11'd0});
    if (ph_c < 0)
      ph_c = ph_c + $signed({2'b0, dh_c, 12'd0}) - $signed({3'b0, dh_c, 10'd0});
    nh_c = 20'(ph_c) + 20'(dh_c[7:1]);

    mxb_c = (pix.base_red > pix.base_green) ? pix.base_red : pix.base_green;
    mnb_c = (pix.base_red < pix.base_green) ? pix.base_red : pix.base_green;
    if (pix.base_blue > mxb_c) mxb_c = pix.base_blue;
    if (pix.base_blue < mnb_c) mnb_c = pix.base_blue;
    db_c = mxb_c - mnb_c;
    ns_c = 18'(db_c) * 18'd510 + 18'(mxb_c[7:1]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      nh_a <= nh_c;
      dh_a <= dh_c;
      ns_a <= ns_c;
      mb_a <= mxb_c;
      db_a <= db_c;
    end
  end

  // stage B: reciprocal multiply
  logic [41:0] prh_b;
  logic [39:0] prs_b;
  logic [19:0] nh_b;
  logic [7:0]  dh_b;
  logic [17:0] ns_b;
  logic [7:0]  mb_b;
  logic        bz_b;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prh_b <= 42'(nh_a) * 42'(hht_pkg::RECIP[dh_a]);
      prs_b <= 40'(ns_a) * 40'(hht_pkg::RECIP[mb_a]);
      nh_b  <= nh_a;
      dh_b  <= dh_a;
      ns_b  <= ns_a;
      mb_b  <= mb_a;
      bz_b  <= (db_a == 8'd0);
    end
  end

  // stage C: one-step correction
  logic [11:0] qh_c, hq_c;
  logic [9:0]  qs_c, sq_c;

  always_comb begin
    qh_c = prh_b[hht_pkg::RECIP_SHIFT +: 12];
    qs_c = prs_b[hht_pkg::RECIP_SHIFT +: 10];
    hq_c = ((20'(qh_c) * 20'(dh_b)) > nh_b) ? qh_c - 12'd1 : qh_c;
    sq_c = ((18'(qs_c) * 18'(mb_b)) > ns_b) ? qs_c - 10'd1 : qs_c;
    if (dh_b == 8'd0 || hq_c >= 12'(hht_pkg::HUE_FULL2)) hq_c = '0;
    if (bz_b) sq_c = '0;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      h2   <= hq_c;
      s2   <= sq_c[8:0];
      vmax <= mb_b;
    end
  end

endmodule

// ===== rtl/core/hht_blend.sv =====
module hht_blend (
  input  logic          clk,
  input  logic [3:0]    en,
  input  logic [11:0]   h2,
  input  logic [8:0]    s2,
  input  logic [7:0]    vmax,
  output hht_pkg::out_t res
);

  // stage D: sector bases and blend weight
  logic [9:0]  cb_c [3];
  logic [18:0] t_d [3];
  logic [7:0]  v_d;
  logic [9:0]  ws_c;

  always_comb begin
    ws_c = 10'd510 - 10'(s2);
    if (h2 < 12'd512) begin
      cb_c[0] = 10'd510; cb_c[1] = h2[9:0]; cb_c[2] = 10'd0;
    end else if (h2 < 12'd1024) begin
      cb_c[0] = 10'(12'd1024 - h2); cb_c[1] = 10'd510; cb_c[2] = 10'd0;
    end else if (h2 < 12'd1536) begin
      cb_c[0] = 10'd0; cb_c[1] = 10'd510; cb_c[2] = 10'(h2 - 12'd1024);
    end else if (h2 < 12'd2048) begin
      cb_c[0] = 10'd0; cb_c[1] = 10'(12'd2048 - h2); cb_c[2] = 10'd510;
    end else if (h2 < 12'd2560) begin
      cb_c[0] = 10'(h2 - 12'd2048); cb_c[1] = 10'd0; cb_c[2] = 10'd510;
    end else begin
      cb_c[0] = 10'd510; cb_c[1] = 10'd0; cb_c[2] = 10'(12'd3072 - h2);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++)
        t_d[k] <= 19'($signed({11'b0, cb_c[k]}) * 21'sd510
                    + ($signed(11'd510) - $signed({1'b0, cb_c[k]}))
                      * $signed({1'b0, ws_c}));
      v_d <= vmax;
    end
  end

  // stage E: scale by value
  logic [27:0] m_e [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++)
        m_e[k] <= 28'(t_d[k]) * 28'(v_d) * 28'd2 + 28'd260100;
    end
  end

  // stage F: reciprocal multiply
  logic [37:0] p_f [3];
  logic [27:0] m_f [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        p_f[k] <= 38'(m_e[k]) * 38'(hht_pkg::BLEND_RECIP);
        m_f[k] <= m_e[k];
      end
    end
  end

  // stage G: correction and saturation
  logic [9:0] q_c [3];
  logic [9:0] r_c [3];
  logic [7:0] o_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_c[k] = p_f[k][hht_pkg::BLEND_SHIFT +: 10];
      r_c[k] = ((30'(q_c[k]) * 30'(hht_pkg::BLEND_DEN2)) > 30'(m_f[k]))
             ? q_c[k] - 10'd1 : q_c[k];
      o_c[k] = (r_c[k] > 10'd255) ? 8'd255 : r_c[k][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      res.out_red   <= o_c[0];
      res.out_green <= o_c[1];
      res.out_blue  <= o_c[2];
    end
  end

endmodule

// ===== rtl/core/hsv_hue_transfer_core.sv =====
// Throughput: one pixel pair per cycle while res_stall is low; each stage holds one item and
// stalled stages collapse bubbles behind them.
// Reset: synchronous rst clears all stage valid bits; datapath is not reset.
module hsv_hue_transfer_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  output logic          pix_stall,
  input  hht_pkg::in_t  pix,
  output logic          res_valid,
  input  logic          res_stall,
  output hht_pkg::out_t res
);

  `include "hsv_hue_transfer_core_assert.svh"

  localparam int N = hht_pkg::STAGES;

  logic [N-1:0] v;
  logic [N-1:0] en;
  logic [11:0]  h2;
  logic [8:0]   s2;
  logic [7:0]   vmax;

  always_comb begin
    en[N-1] = !v[N-1] || !res_stall;
    for (int i = N - 2; i >= 0; i--)
      en[i] = !v[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= pix_valid;
      for (int i = 1; i < N; i++)
        if (en[i]) v[i] <= v[i-1];
    end
  end

  assign pix_stall = !en[0];
  assign res_valid = v[N-1];

  hht_hsv u_hsv (
    .clk  (clk),
    .en   (en[2:0]),
    .pix  (pix),
    .h2   (h2),
    .s2   (s2),
    .vmax (vmax)
  );

  hht_blend u_blend (
    .clk  (clk),
    .en   (en[6:3]),
    .h2   (h2),
    .s2   (s2),
    .vmax (vmax),
    .res  (res)
  );

  `HHT_ASSERT_NEXT(a_enter, pix_valid && !pix_stall, v[0])
  `HHT_ASSERT_SAME(a_full_stall, (&v) && res_stall, pix_stall)
  `HHT_ASSERT_SAME(a_drain_open, !v[N-1], !pix_stall)
  `HHT_ASSERT_NEXT(a_no_invent, res_valid && !res_stall && !v[N-2], !res_valid)

endmodule
